FILE: sv/dawg_pkg.sv
// ----------------------------------------------------------------------------
// dawg_pkg
// Shared types and constants for the word graph lookup block.
// ----------------------------------------------------------------------------
package dawg_pkg;

  localparam int NODE_COUNT   = 4096;
  localparam int MAX_CHILDREN = 256;
  localparam int IDX_W        = 12;
  localparam int SIZE_W       = 9;
  localparam int LETTER_W     = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT_BEGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_SIZE  = 1'b1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [IDX_W-1:0]    begin_idx;
    logic                accept;
    logic [LETTER_W-1:0] letter;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic wr;
    logic prep;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic hit;
    logic exhausted;
  } sts_t;

endpackage

FILE: sv/dawg_ram.sv
// ----------------------------------------------------------------------------
// dawg_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dawg_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/dawg_dp.sv
// ----------------------------------------------------------------------------
// dawg_dp
// Datapath: word capture, node table, child set scan and walk state.
// ----------------------------------------------------------------------------
module dawg_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  dawg_pkg::cmd_t                      cmd,
  output dawg_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [dawg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dawg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [dawg_pkg::IDX_W-1:0]          entry_index,
  input  logic [dawg_pkg::LETTER_W-1:0]       entry_letter,
  input  logic                                entry_accept,
  input  logic [dawg_pkg::IDX_W-1:0]          entry_begin,
  input  logic [dawg_pkg::SIZE_W-1:0]         entry_size,
  input  logic [dawg_pkg::LETTER_W-1:0]       ch,
  input  logic                                last_char,
  output logic                                matched,
  output logic                                accept,
  output logic [dawg_pkg::IDX_W-1:0]          node_index,
  output logic                                word_end,
  output logic                                was_write
);

  logic [dawg_pkg::IDX_W-1:0]    root_begin;
  logic [dawg_pkg::SIZE_W-1:0]   root_size;
  logic [dawg_pkg::IDX_W-1:0]    cur_begin;
  logic [dawg_pkg::SIZE_W-1:0]   cur_size;
  logic                          word_dead;
  logic                          at_root;

  logic [dawg_pkg::IDX_W-1:0]    q_index;
  dawg_pkg::entry_t              q_entry;
  logic [dawg_pkg::LETTER_W-1:0] q_ch;
  logic                          q_last;

  logic [dawg_pkg::IDX_W-1:0]    pos;
  logic [dawg_pkg::SIZE_W-1:0]   left;
  logic                          pend;
  logic [dawg_pkg::IDX_W-1:0]    pend_pos;

  logic [dawg_pkg::IDX_W-1:0]    set_begin;
  logic [dawg_pkg::SIZE_W-1:0]   set_size_raw;
  logic [dawg_pkg::SIZE_W-1:0]   set_size;
  logic [dawg_pkg::IDX_W-1:0]    ram_addr;
  logic [dawg_pkg::ENTRY_W-1:0]  ram_rdata;
  dawg_pkg::entry_t              rd_entry;
  logic                          fin_miss;

  assign set_begin    = at_root ? root_begin : cur_begin;
  assign set_size_raw = at_root ? root_size : cur_size;
  assign set_size     = (set_size_raw > dawg_pkg::SIZE_W'(dawg_pkg::MAX_CHILDREN))
                        ? dawg_pkg::SIZE_W'(dawg_pkg::MAX_CHILDREN) : set_size_raw;

  assign rd_entry      = dawg_pkg::entry_t'(ram_rdata);
  assign sts.skip      = word_dead || (set_size == '0);
  assign sts.hit       = pend && (rd_entry.letter == q_ch);
  assign sts.exhausted = !pend && (left == '0);
  assign fin_miss      = (cmd.prep && sts.skip) || (cmd.scan && sts.exhausted);
  assign ram_addr      = cmd.wr ? q_index : pos;

  dawg_ram #(
    .WIDTH(dawg_pkg::ENTRY_W),
    .DEPTH(dawg_pkg::NODE_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (cmd.wr),
    .addr (ram_addr),
    .wdata(q_entry),
    .rdata(ram_rdata)
  );

  // capture word and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_index         <= entry_index;
      q_entry.letter  <= entry_letter;
      q_entry.accept  <= entry_accept;
      q_entry.begin_idx <= entry_begin;
      q_entry.size    <= entry_size;
      q_ch            <= ch;
      q_last          <= last_char;
    end
    if (cmd.prep) begin
      pos  <= set_begin;
      left <= set_size;
      pend <= 1'b0;
    end else if (cmd.scan && !sts.hit) begin
      if (left != '0) begin
        pos      <= pos + 1'b1;
        left     <= left - 1'b1;
        pend     <= 1'b1;
        pend_pos <= pos;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  // results
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      matched    <= 1'b0;
      accept     <= 1'b0;
      node_index <= '0;
      word_end   <= 1'b0;
      was_write  <= 1'b1;
    end else if (cmd.scan && sts.hit) begin
      matched    <= 1'b1;
      accept     <= rd_entry.accept;
      node_index <= pend_pos;
      word_end   <= q_last;
      was_write  <= 1'b0;
    end else if (fin_miss) begin
      matched    <= 1'b0;
      accept     <= 1'b0;
      node_index <= '0;
      word_end   <= q_last;
      was_write  <= 1'b0;
    end
  end

  // configuration and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      root_begin <= '0;
      root_size  <= '0;
      word_dead  <= 1'b0;
      at_root    <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dawg_pkg::REG_ROOT_BEGIN: root_begin <= cfg_data[dawg_pkg::IDX_W-1:0];
          dawg_pkg::REG_ROOT_SIZE:  root_size  <= cfg_data[dawg_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.scan && sts.hit) begin
        cur_begin <= rd_entry.begin_idx;
        cur_size  <= rd_entry.size;
        at_root   <= q_last;
        word_dead <= 1'b0;
      end else if (fin_miss) begin
        at_root   <= q_last;
        word_dead <= !q_last;
      end
    end
  end

endmodule

FILE: sv/dawg_ctrl.sv
// ----------------------------------------------------------------------------
// dawg_ctrl
// Controller: sequences table writes and child set scans.
// ----------------------------------------------------------------------------
module dawg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           kind,
  output logic           busy,
  output logic           done,
  output dawg_pkg::cmd_t cmd,
  input  dawg_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_SCAN
  } state_t;

  state_t state;

  assign cmd.load = (state == ST_IDLE) && start;
  assign cmd.wr   = (state == ST_WRITE);
  assign cmd.prep = (state == ST_CHECK);
  assign cmd.scan = (state == ST_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= (kind == dawg_pkg::KIND_LOOKUP) ? ST_CHECK : ST_WRITE;
            busy  <= 1'b1;
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        ST_CHECK: begin
          if (sts.skip) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts.hit || sts.exhausted) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sv/dawg_word_lookup.sv
// ----------------------------------------------------------------------------
// dawg_word_lookup
// Word graph walker over a node table, one character per lookup.
// Table write: the table is written in the write state, then done pulses.
// Lookup: a check state, then a scan that probes the set in order until a hit or a miss
// over the whole set; a dead word or an empty set ends at the check. One table read per cycle.
// Next word accepted in the cycle done pulses; results cannot be stalled.
// Reset clears control and walk state; node table contents stay undefined.
// ----------------------------------------------------------------------------
module dawg_word_lookup (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [dawg_pkg::IDX_W-1:0]      entry_index,
  input  logic [dawg_pkg::LETTER_W-1:0]   entry_letter,
  input  logic                            entry_accept,
  input  logic [dawg_pkg::IDX_W-1:0]      entry_begin,
  input  logic [dawg_pkg::SIZE_W-1:0]     entry_size,
  input  logic [dawg_pkg::LETTER_W-1:0]   ch,
  input  logic                            last_char,
  output logic                            done,
  output logic                            matched,
  output logic                            accept,
  output logic [dawg_pkg::IDX_W-1:0]      node_index,
  output logic                            word_end,
  output logic                            was_write,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dawg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dawg_pkg::CFG_DATA_W-1:0] cfg_data
);

  dawg_pkg::cmd_t cmd;
  dawg_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dawg_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .kind (kind),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .sts  (sts)
  );

  dawg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry_index (entry_index),
    .entry_letter(entry_letter),
    .entry_accept(entry_accept),
    .entry_begin (entry_begin),
    .entry_size  (entry_size),
    .ch          (ch),
    .last_char   (last_char),
    .matched     (matched),
    .accept      (accept),
    .node_index  (node_index),
    .word_end    (word_end),
    .was_write   (was_write)
  );

endmodule

FILE: tb/dawg_word_lookup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dawg_word_lookup_test
// Self-checking regression for the word graph walker. A 256-entry window of
// the node table (wrapping from 0xF80 through 0x07F) is loaded first. Every
// child set stored in the window and every root set then stay inside it, so
// no scan ever reaches an entry that was never loaded. A short directed list
// covers reset state, extremes, wrap, saturation, dead words and register
// changes in the middle of a word. Random traffic follows: words built mostly
// from letters present in the set being walked, interleaved with table
// rewrites and stray characters. Results are compared field by field, in order
// of arrival, against a local walker or a directed row's expected values.
// ----------------------------------------------------------------------------
module dawg_word_lookup_test;

  localparam logic [dawg_pkg::IDX_W-1:0]    WIN_BASE     = 12'hF80;
  localparam logic [dawg_pkg::LETTER_W-1:0] PROBE_MISS   = 8'hA5;
  localparam int                            RANDOM_ITEMS = 575;
  localparam int                            CYCLE_LIMIT  = 1000000;
  localparam int                            DRAIN_TAIL   = 300;
  localparam int                            PLAN_ROWS    = 27;

  typedef struct packed {
    logic                          kind;
    logic [dawg_pkg::IDX_W-1:0]    index;
    logic [dawg_pkg::LETTER_W-1:0] letter;
    logic                          acc;
    logic [dawg_pkg::IDX_W-1:0]    child_begin;
    logic [dawg_pkg::SIZE_W-1:0]   child_size;
    logic [dawg_pkg::LETTER_W-1:0] ch;
    logic                          fin;
  } req_t;

  typedef struct packed {
    logic                       matched;
    logic                       acc;
    logic [dawg_pkg::IDX_W-1:0] node;
    logic                       word_end;
    logic                       was_write;
  } res_t;

  typedef enum logic {STEP_ITEM, STEP_REG} step_t;

  typedef struct {
    step_t                           op;
    req_t                            req;
    logic [dawg_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [dawg_pkg::CFG_DATA_W-1:0] reg_val;
    bit                              typed;
    res_t                            want;
  } row_t;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic                            kind;
  logic [dawg_pkg::IDX_W-1:0]      entry_index;
  logic [dawg_pkg::LETTER_W-1:0]   entry_letter;
  logic                            entry_accept;
  logic [dawg_pkg::IDX_W-1:0]      entry_begin;
  logic [dawg_pkg::SIZE_W-1:0]     entry_size;
  logic [dawg_pkg::LETTER_W-1:0]   ch;
  logic                            last_char;
  logic                            done;
  logic                            matched;
  logic                            accept;
  logic [dawg_pkg::IDX_W-1:0]      node_index;
  logic                            word_end;
  logic                            was_write;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dawg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dawg_pkg::CFG_DATA_W-1:0] cfg_data;

  dawg_word_lookup dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_letter(entry_letter),
    .entry_accept(entry_accept),
    .entry_begin (entry_begin),
    .entry_size  (entry_size),
    .ch          (ch),
    .last_char   (last_char),
    .done        (done),
    .matched     (matched),
    .accept      (accept),
    .node_index  (node_index),
    .word_end    (word_end),
    .was_write   (was_write),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  dawg_pkg::entry_t            node_mem [dawg_pkg::NODE_COUNT];
  logic [dawg_pkg::IDX_W-1:0]  root_begin_q = '0;
  logic [dawg_pkg::SIZE_W-1:0] root_size_q  = '0;
  logic [dawg_pkg::IDX_W-1:0]  cur_begin_q  = '0;
  logic [dawg_pkg::SIZE_W-1:0] cur_size_q   = '0;
  bit                          walk_dead    = 1'b0;
  bit                          walk_at_root = 1'b1;

  res_t walk_results_due [$];
  res_t head;
  row_t plan [PLAN_ROWS];

  int failures  = 0;
  int cycles    = 0;
  int n_checked = 0;
  int n_writes  = 0;
  int n_lookups = 0;
  int n_hits    = 0;
  int n_words   = 0;
  int n_regs    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_set(logic [dawg_pkg::SIZE_W-1:0] s);
    return (s > dawg_pkg::MAX_CHILDREN) ? dawg_pkg::MAX_CHILDREN : int'(s);
  endfunction

  function automatic res_t walk_node_graph(req_t r);
    res_t                       o;
    dawg_pkg::entry_t           e;
    logic [dawg_pkg::IDX_W-1:0] b;
    logic [dawg_pkg::IDX_W-1:0] p;
    int                         n;
    int                         i;
    bit                         hit;
    o = '0;
    if (r.kind == dawg_pkg::KIND_WRITE) begin
      e.letter    = r.letter;
      e.accept    = r.acc;
      e.begin_idx = r.child_begin;
      e.size      = r.child_size;
      node_mem[r.index] = e;
      o.was_write = 1'b1;
      return o;
    end
    if (!walk_dead) begin
      b   = walk_at_root ? root_begin_q : cur_begin_q;
      n   = clamp_set(walk_at_root ? root_size_q : cur_size_q);
      hit = 1'b0;
      for (i = 0; i < n && !hit; i++) begin
        p = b + dawg_pkg::IDX_W'(i);
        e = node_mem[p];
        if (e.letter == r.ch) begin
          hit         = 1'b1;
          o.matched   = 1'b1;
          o.acc       = e.accept;
          o.node      = p;
          cur_begin_q = e.begin_idx;
          cur_size_q  = e.size;
        end
      end
      if (!hit) walk_dead = 1'b1;
    end
    walk_at_root = 1'b0;
    if (r.fin) begin
      cur_begin_q  = root_begin_q;
      cur_size_q   = root_size_q;
      walk_dead    = 1'b0;
      walk_at_root = 1'b1;
    end
    o.word_end = r.fin;
    return o;
  endfunction

  function automatic req_t rand_req();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic logic [dawg_pkg::LETTER_W-1:0] any_letter();
    if ($urandom_range(0, 3) == 0) return dawg_pkg::LETTER_W'($urandom);
    return 8'h61 + dawg_pkg::LETTER_W'($urandom_range(0, 7));
  endfunction

  // keep every child set inside the loaded window
  function automatic void pick_children(output logic [dawg_pkg::IDX_W-1:0] b,
                                        output logic [dawg_pkg::SIZE_W-1:0] s);
    int pos;
    int roll;
    int room;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      b = dawg_pkg::IDX_W'($urandom);
      s = '0;
    end else if (roll < 13) begin
      b = WIN_BASE;
      s = (roll == 10) ? dawg_pkg::SIZE_W'(dawg_pkg::MAX_CHILDREN)
                       : dawg_pkg::SIZE_W'($urandom_range(257, 511));
    end else begin
      pos  = $urandom_range(0, 255);
      room = 256 - pos;
      b    = WIN_BASE + dawg_pkg::IDX_W'(pos);
      if (roll < 18) s = dawg_pkg::SIZE_W'($urandom_range(1, room));
      else s = dawg_pkg::SIZE_W'($urandom_range(1, (room < 5) ? room : 5));
    end
  endfunction

  function automatic req_t graph_write(int pos, bit spare_probe);
    req_t r;
    r        = rand_req();
    r.kind   = dawg_pkg::KIND_WRITE;
    r.index  = WIN_BASE + dawg_pkg::IDX_W'(pos);
    r.letter = any_letter();
    if (spare_probe && r.letter == PROBE_MISS) r.letter = 8'h61;
    pick_children(r.child_begin, r.child_size);
    return r;
  endfunction

  // favor letters present in the set about to be scanned
  function automatic logic [dawg_pkg::LETTER_W-1:0] next_char();
    logic [dawg_pkg::IDX_W-1:0] b;
    int                         n;
    b = walk_at_root ? root_begin_q : cur_begin_q;
    n = clamp_set(walk_at_root ? root_size_q : cur_size_q);
    if (!walk_dead && n > 0 && $urandom_range(0, 99) < 75)
      return node_mem[b + dawg_pkg::IDX_W'($urandom_range(0, n - 1))].letter;
    return any_letter();
  endfunction

  function automatic row_t lk(logic [dawg_pkg::LETTER_W-1:0] c, logic fin, bit typed,
                              logic m, logic a, logic [dawg_pkg::IDX_W-1:0] node);
    row_t r;
    r.op      = STEP_ITEM;
    r.req     = rand_req();
    r.req.kind = dawg_pkg::KIND_LOOKUP;
    r.req.ch  = c;
    r.req.fin = fin;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.typed   = typed;
    r.want    = '{matched: m, acc: a, node: node, word_end: fin, was_write: 1'b0};
    return r;
  endfunction

  function automatic row_t wr(logic [dawg_pkg::IDX_W-1:0] idx,
                              logic [dawg_pkg::LETTER_W-1:0] letter, logic acc,
                              logic [dawg_pkg::IDX_W-1:0] b,
                              logic [dawg_pkg::SIZE_W-1:0] s);
    row_t r;
    r.op              = STEP_ITEM;
    r.req             = rand_req();
    r.req.kind        = dawg_pkg::KIND_WRITE;
    r.req.index       = idx;
    r.req.letter      = letter;
    r.req.acc         = acc;
    r.req.child_begin = b;
    r.req.child_size  = s;
    r.reg_idx         = '0;
    r.reg_val         = '0;
    r.typed           = 1'b1;
    r.want            = '{matched: 1'b0, acc: 1'b0, node: '0, word_end: 1'b0,
                          was_write: 1'b1};
    return r;
  endfunction

  function automatic row_t rg(logic [dawg_pkg::CFG_IDX_W-1:0] i,
                              logic [dawg_pkg::CFG_DATA_W-1:0] v);
    row_t r;
    r.op      = STEP_REG;
    r.req     = '0;
    r.reg_idx = i;
    r.reg_val = v;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [dawg_pkg::IDX_W-1:0] exp_v,
                                      logic [dawg_pkg::IDX_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      failures++;
    end
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [dawg_pkg::CFG_IDX_W-1:0] idx,
                           logic [dawg_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == dawg_pkg::REG_ROOT_BEGIN) root_begin_q = val;
    else root_size_q = val[dawg_pkg::SIZE_W-1:0];
    n_regs++;
  endtask

  task automatic issue(req_t r, bit typed, res_t want);
    res_t model;
    start        <= 1'b1;
    kind         <= r.kind;
    entry_index  <= r.index;
    entry_letter <= r.letter;
    entry_accept <= r.acc;
    entry_begin  <= r.child_begin;
    entry_size   <= r.child_size;
    ch           <= r.ch;
    last_char    <= r.fin;
    do @(posedge clk); while (busy !== 1'b0);
    model = walk_node_graph(r);
    walk_results_due.push_back(typed ? want : model);
    if (r.kind == dawg_pkg::KIND_WRITE) begin
      n_writes++;
    end else begin
      n_lookups++;
      if (model.matched) n_hits++;
      if (r.fin) n_words++;
    end
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // root set always stays inside the window, or is empty
  task automatic program_root();
    logic [dawg_pkg::IDX_W-1:0]  b;
    logic [dawg_pkg::SIZE_W-1:0] s;
    int                          pos;
    case ($urandom_range(0, 4))
      0: begin
        b = WIN_BASE;
        s = $urandom_range(0, 1) ? dawg_pkg::SIZE_W'(dawg_pkg::MAX_CHILDREN)
                                 : dawg_pkg::SIZE_W'($urandom_range(257, 511));
      end
      1: begin
        b = '0;
        s = dawg_pkg::SIZE_W'($urandom_range(1, 128));
      end
      2: begin
        b = '1;
        s = dawg_pkg::SIZE_W'($urandom_range(1, 129));
      end
      3: begin
        b = dawg_pkg::IDX_W'($urandom);
        s = '0;
      end
      default: begin
        pos = $urandom_range(0, 255);
        b   = WIN_BASE + dawg_pkg::IDX_W'(pos);
        s   = dawg_pkg::SIZE_W'($urandom_range(1, (256 - pos < 8) ? 256 - pos : 8));
      end
    endcase
    write_reg(dawg_pkg::REG_ROOT_BEGIN, b);
    write_reg(dawg_pkg::REG_ROOT_SIZE,
              {(dawg_pkg::CFG_DATA_W - dawg_pkg::SIZE_W)'($urandom), s});
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (walk_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual m=%0b a=%0b node=%0h",
                 $time, matched, accept, node_index);
        $display("%0t:   end=%0b wr=%0b", $time, word_end, was_write);
        failures++;
      end else begin
        head = walk_results_due.pop_front();
        check_field("matched", dawg_pkg::IDX_W'(head.matched), dawg_pkg::IDX_W'(matched));
        check_field("accept", dawg_pkg::IDX_W'(head.acc), dawg_pkg::IDX_W'(accept));
        check_field("node_index", head.node, node_index);
        check_field("word_end", dawg_pkg::IDX_W'(head.word_end),
                    dawg_pkg::IDX_W'(word_end));
        check_field("was_write", dawg_pkg::IDX_W'(head.was_write),
                    dawg_pkg::IDX_W'(was_write));
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, walk_results_due.size());
      $display("dawg_word_lookup regression: fail");
      $finish;
    end
  end

  initial begin
    req_t r;
    int   k;
    int   items;
    int   phase_len;
    int   idle_pct;
    int   word_left;
    rst          <= 1'b1;
    start        <= 1'b0;
    kind         <= dawg_pkg::KIND_WRITE;
    entry_index  <= '0;
    entry_letter <= '0;
    entry_accept <= 1'b0;
    entry_begin  <= '0;
    entry_size   <= '0;
    ch           <= '0;
    last_char    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= dawg_pkg::REG_ROOT_BEGIN;
    cfg_data     <= '0;
    plan = '{
      lk(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 12'h000),
      lk(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 12'h000),
      wr(12'hFFF, 8'h00, 1'b1, 12'h000, 9'd0),
      wr(12'h000, 8'hFF, 1'b0, 12'hFFF, 9'd2),
      wr(12'h800, 8'hFF, 1'b1, 12'hFFF, 9'h1FF),
      rg(dawg_pkg::REG_ROOT_BEGIN, 12'hFFF),
      rg(dawg_pkg::REG_ROOT_SIZE, 12'h002),
      lk(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 12'hFFF),
      lk(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 12'h000),
      lk(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 12'h000),
      lk(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 12'hFFF),
      rg(dawg_pkg::REG_ROOT_BEGIN, WIN_BASE),
      rg(dawg_pkg::REG_ROOT_SIZE, 12'h1FF),
      lk(PROBE_MISS, 1'b1, 1'b1, 1'b0, 1'b0, 12'h000),
      lk(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 12'h000),
      rg(dawg_pkg::REG_ROOT_SIZE, 12'h100),
      lk(8'h61, 1'b0, 1'b0, 1'b0, 1'b0, 12'h000),
      rg(dawg_pkg::REG_ROOT_BEGIN, 12'h000),
      rg(dawg_pkg::REG_ROOT_SIZE, 12'hE01),
      lk(8'h62, 1'b1, 1'b0, 1'b0, 1'b0, 12'h000),
      lk(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 12'h000),
      lk(PROBE_MISS, 1'b0, 1'b1, 1'b0, 1'b0, 12'h000),
      lk(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 12'h000),
      wr(12'h001, 8'h7A, 1'b1, WIN_BASE, 9'h1FF),
      rg(dawg_pkg::REG_ROOT_SIZE, 12'h002),
      lk(8'h7A, 1'b0, 1'b1, 1'b1, 1'b1, 12'h001),
      lk(PROBE_MISS, 1'b1, 1'b1, 1'b0, 1'b0, 12'h000)
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // load the whole window before anything scans it
    for (k = 0; k < 256; k++) begin
      maybe_idle(10);
      issue(graph_write(k, 1'b1), 1'b0, '0);
    end

    for (k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].op == STEP_REG) begin
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        maybe_idle(25);
        issue(plan[k].req, plan[k].typed, plan[k].want);
      end
    end

    items     = 0;
    word_left = 0;
    while (items < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 140);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 40;
      endcase
      program_root();
      for (k = 0; k < phase_len && items < RANDOM_ITEMS; k++) begin
        // hold the tail of the run free of gaps
        if (items < RANDOM_ITEMS - 100) maybe_idle(idle_pct);
        r = rand_req();
        if ($urandom_range(0, 99) < 18) begin
          if ($urandom_range(0, 4) == 0) begin
            r.kind  = dawg_pkg::KIND_WRITE;
            r.index = WIN_BASE + dawg_pkg::IDX_W'($urandom_range(256, 4095));
          end else begin
            r = graph_write($urandom_range(0, 255), 1'b0);
          end
        end else begin
          if (word_left == 0) word_left = $urandom_range(1, 6);
          r.kind = dawg_pkg::KIND_LOOKUP;
          r.ch   = next_char();
          r.fin  = (word_left == 1);
          word_left--;
        end
        issue(r, 1'b0, '0);
        items++;
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("covered %0d table writes and %0d lookups (%0d matched, %0d words closed)",
             n_writes, n_lookups, n_hits, n_words);
    $display("across %0d root register writes; %0d results checked, %0d mismatches",
             n_regs, n_checked, failures);
    if (failures == 0 && walk_results_due.size() == 0)
      $display("dawg_word_lookup regression: pass");
    else
      $display("dawg_word_lookup regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
sv/dawg_pkg.sv
sv/dawg_ram.sv
sv/dawg_dp.sv
sv/dawg_ctrl.sv
sv/dawg_word_lookup.sv
tb/dawg_word_lookup_test.sv
